// ===== src/u8u16_pkg.sv =====
// Shared constants and types for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned PointW = 21;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [UnitW-1:0]  unit_t;
  typedef logic [PointW-1:0] point_t;
  typedef logic [1:0]        expect_t;

  // Number of code units waiting in the result buffer.
  typedef logic [1:0] fill_t;
  localparam fill_t FillEmpty = 2'd0;
  localparam fill_t FillOne   = 2'd1;
  localparam fill_t FillTwo   = 2'd2;

  localparam unit_t  HighSurrBase = 16'hD800;
  localparam unit_t  LowSurrBase  = 16'hDC00;
  localparam point_t SuppBase     = 21'h10000;

  // Kind of a byte when it is taken as the start of a sequence.
  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_STRAY
  } lead_kind_t;

  function automatic lead_kind_t lead_kind(input byte_t b);
    lead_kind_t k;
    if (b[7] == 1'b0) begin
      k = LEAD_ASCII;
    end else if (b[7:5] == 3'b110) begin
      k = LEAD_TWO;
    end else if (b[7:4] == 4'b1110) begin
      k = LEAD_THREE;
    end else if (b[7:3] == 5'b11110) begin
      k = LEAD_FOUR;
    end else begin
      k = LEAD_STRAY;
    end
    return k;
  endfunction

endpackage

// ===== src/u8u16_ifs.sv =====
// Valid/ready channel interfaces for input bytes and output code units.
interface u8u16_in_if;
  import u8u16_pkg::*;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  end_of_string;
  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface u8u16_out_if;
  import u8u16_pkg::*;
  logic  valid;
  logic  ready;
  unit_t code_unit;
  logic  last_of_run;
  logic  string_end;
  modport source (output valid, output code_unit, output last_of_run, output string_end,
                  input ready);
  modport sink   (input valid, input code_unit, input last_of_run, input string_end,
                  output ready);
endinterface

// ===== src/utf8_to_utf16_transcoder_top.sv =====
// UTF-8 to UTF-16 transcoder: byte decode, sequence state and result buffer.
//   in_chan carries one UTF-8 byte per beat, with end_of_string on the final
//   byte of a string. out_chan carries UTF-16 code units; last_of_run marks
//   the last unit caused by one input byte and string_end copies the
//   end_of_string flag of that byte.
//   A byte is decoded in the cycle it is accepted, against the pending
//   sequence state, and its units land in a two-entry result buffer, so the
//   first unit is visible in the cycle after the byte beat.
//   Throughput is one byte per cycle while the receiver is ready. A byte that
//   completes a supplementary code point gives a surrogate pair, which leaves
//   the buffer as two units in turn; the buffer draining its second unit is
//   what can hold off the next byte.
//   in_chan.ready is high when the buffer is empty, or holds its last unit
//   and the receiver takes it in this cycle. When the receiver stalls, the
//   buffered units hold and input stalls behind them; no unit is lost.
//   Framing errors never produce units (overlong forms pass unchecked):
//   stray bytes are dropped, a broken sequence restarts at the offending
//   byte, and a sequence cut short by end_of_string is discarded.
//   Reset (rst_n low, synchronous) empties the buffer and clears the
//   pending sequence.
module utf8_to_utf16_transcoder_top (
  input  logic                clk,
  input  logic                rst_n,
  u8u16_in_if.sink            in_chan,
  u8u16_out_if.source         out_chan
);
  import u8u16_pkg::*;

  // Sequence state.
  point_t  pcp_r, pcp_nxt;
  expect_t exp_r, exp_nxt;

  // Result buffer.
  unit_t u0_r, u0_nxt;
  unit_t u1_r, u1_nxt;
  fill_t cnt_r, cnt_nxt;
  logic  fin_r, fin_nxt;

  logic       in_beat, out_beat;
  byte_t      b;
  logic       cont;
  logic       emit;
  point_t     cp;
  point_t     shifted;
  point_t     supp;
  logic       is_supp;
  unit_t      hi_unit, lo_unit;
  lead_kind_t kind;

  // Handshake.
  assign out_beat      = out_chan.valid && out_chan.ready;
  assign in_chan.ready = (cnt_r == FillEmpty) || ((cnt_r == FillOne) && out_chan.ready);
  assign in_beat       = in_chan.valid && in_chan.ready;

  // Byte decode against the pending sequence.
  assign b       = in_chan.data_byte;
  assign cont    = (exp_r != 2'd0) && (b[7:6] == 2'b10);
  assign shifted = {pcp_r[PointW-7:0], b[5:0]};
  assign kind    = lead_kind(b);

  always_comb begin
    pcp_nxt = pcp_r;
    exp_nxt = exp_r;
    emit    = 1'b0;
    cp      = shifted;
    if (in_beat) begin
      if (cont) begin
        exp_nxt = exp_r - 2'd1;
        if (exp_r == 2'd1) begin
          emit    = 1'b1;
          pcp_nxt = '0;
        end else begin
          pcp_nxt = shifted;
        end
      end else begin
        // Not an awaited continuation: restart with this byte as a lead.
        pcp_nxt = '0;
        exp_nxt = 2'd0;
        unique case (kind)
          LEAD_ASCII: begin
            emit = 1'b1;
            cp   = {{(PointW-ByteW){1'b0}}, b};
          end
          LEAD_TWO: begin
            pcp_nxt = {{(PointW-5){1'b0}}, b[4:0]};
            exp_nxt = 2'd1;
          end
          LEAD_THREE: begin
            pcp_nxt = {{(PointW-4){1'b0}}, b[3:0]};
            exp_nxt = 2'd2;
          end
          LEAD_FOUR: begin
            pcp_nxt = {{(PointW-3){1'b0}}, b[2:0]};
            exp_nxt = 2'd3;
          end
          default: begin
          end
        endcase
      end
      // A sequence still open at the end of a string is discarded.
      if (in_chan.end_of_string) begin
        pcp_nxt = '0;
        exp_nxt = 2'd0;
      end
    end
  end

  // Code point to one unit or a surrogate pair.
  assign is_supp = (cp[PointW-1:UnitW] != '0);
  assign supp    = cp - SuppBase;
  assign hi_unit = HighSurrBase + {{(UnitW-11){1'b0}}, supp[20:10]};
  assign lo_unit = LowSurrBase | {{(UnitW-10){1'b0}}, supp[9:0]};

  // Result buffer update: pop first, then load a fresh byte's units.
  always_comb begin
    u0_nxt  = u0_r;
    u1_nxt  = u1_r;
    cnt_nxt = cnt_r;
    fin_nxt = fin_r;
    if (out_beat) begin
      u0_nxt  = u1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
    if (in_beat) begin
      fin_nxt = in_chan.end_of_string;
      if (emit) begin
        if (is_supp) begin
          u0_nxt  = hi_unit;
          u1_nxt  = lo_unit;
          cnt_nxt = FillTwo;
        end else begin
          u0_nxt  = cp[UnitW-1:0];
          cnt_nxt = FillOne;
        end
      end else begin
        cnt_nxt = FillEmpty;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcp_r <= '0;
      exp_r <= 2'd0;
      cnt_r <= FillEmpty;
    end else begin
      pcp_r <= pcp_nxt;
      exp_r <= exp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    u0_r  <= u0_nxt;
    u1_r  <= u1_nxt;
    fin_r <= fin_nxt;
  end

  // Output beat.
  assign out_chan.valid       = (cnt_r != FillEmpty);
  assign out_chan.code_unit   = u0_r;
  assign out_chan.last_of_run = (cnt_r == FillOne);
  assign out_chan.string_end  = fin_r;

`ifndef ASSERT_OFF
  // The buffer never holds more than a surrogate pair.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer fill out of range");

  // A waiting second unit is always a low surrogate.
  a_low_surr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == FillTwo) |-> (u1_r[15:10] == 6'b110111))
    else $error("second buffered unit is not a low surrogate");

  // No sequence survives the end of a string.
  a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_chan.end_of_string) |=> (exp_r == 2'd0 && pcp_r == '0))
    else $error("sequence state not cleared at end of string");

  // Input is never taken while a unit would be overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |-> (cnt_r == FillEmpty || (cnt_r == FillOne && out_beat)))
    else $error("byte accepted over an undelivered unit");
`endif

endmodule

// ===== tb/sv/u8u16_stream_check.sv =====
// Monitor that predicts UTF-16 code units from accepted bytes and checks every output beat.
module u8u16_stream_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  u8u16_pkg::byte_t   in_data_byte,
  input  logic               in_end_of_string,
  input  logic               out_valid,
  input  logic               out_ready,
  input  u8u16_pkg::unit_t   out_code_unit,
  input  logic               out_last_of_run,
  input  logic               out_string_end,
  output int                 fail_count,
  output int                 units_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import u8u16_pkg::*;

  // One predicted output beat.
  typedef struct packed {
    unit_t code_unit;
    logic  last_of_run;
    logic  string_end;
  } unit_beat_t;

  unit_beat_t units_due[$];
  point_t     partial_point;
  expect_t    conts_owed;

  initial begin
    fail_count    = 0;
    units_pending = 0;
    partial_point = '0;
    conts_owed    = '0;
  end

  // Queue the one or two code units that a finished code point turns into.
  task automatic queue_point(input point_t cp, input logic eos);
    point_t     offset;
    unit_beat_t ub;
    if (cp <= point_t'(21'h00FFFF)) begin
      ub        = '{cp[UnitW-1:0], 1'b1, eos};
      units_due = {units_due, ub};
    end else begin
      offset    = cp - SuppBase;
      ub        = '{HighSurrBase + unit_t'(offset[20:10]), 1'b0, eos};
      units_due = {units_due, ub};
      ub        = '{LowSurrBase + unit_t'(offset[9:0]), 1'b1, eos};
      units_due = {units_due, ub};
    end
  endtask

  // Advance the sequence state by one byte and queue whatever it completes.
  task automatic decode_byte(input byte_t b, input logic eos);
    logic as_lead;
    as_lead = 1'b1;
    if (conts_owed != '0) begin
      if (b[7:6] == 2'b10) begin
        as_lead       = 1'b0;
        partial_point = {partial_point[PointW-7:0], b[5:0]};
        conts_owed    = conts_owed - 2'd1;
        if (conts_owed == '0) begin
          queue_point(partial_point, eos);
          partial_point = '0;
        end
      end else begin
        // The awaited continuation is missing, so the byte starts over as a lead.
        partial_point = '0;
        conts_owed    = '0;
      end
    end
    if (as_lead) begin
      casez (b)
        8'b0???????: begin
          queue_point(point_t'(b), eos);
        end
        8'b110?????: begin
          partial_point = point_t'(b[4:0]);
          conts_owed    = 2'd1;
        end
        8'b1110????: begin
          partial_point = point_t'(b[3:0]);
          conts_owed    = 2'd2;
        end
        8'b11110???: begin
          partial_point = point_t'(b[2:0]);
          conts_owed    = 2'd3;
        end
        default: begin
          // Stray continuation or 11111xxx byte: dropped.
        end
      endcase
    end
    // The end of a string discards any unfinished sequence.
    if (eos) begin
      partial_point = '0;
      conts_owed    = '0;
    end
  endtask

  task automatic check_field(input string field, input logic [UnitW-1:0] want,
                             input logic [UnitW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      fail_count++;
    end
  endtask

  // Output beats are checked before the input beat of the same edge is decoded,
  // since a unit never leaves in the cycle its byte is taken.
  always @(posedge clk) begin
    unit_beat_t due;
    if (!rst_n) begin
      units_due.delete();
      partial_point = '0;
      conts_owed    = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (units_due.size() == 0) begin
          $display("%0t: unexpected code unit, expected none, actual %h last %b end %b",
                   $time, out_code_unit, out_last_of_run, out_string_end);
          fail_count++;
        end else begin
          due = units_due.pop_front();
          check_field("code_unit", due.code_unit, out_code_unit);
          check_field("last_of_run", UnitW'(due.last_of_run), UnitW'(out_last_of_run));
          check_field("string_end", UnitW'(due.string_end), UnitW'(out_string_end));
        end
      end
      if (in_valid && in_ready) begin
        decode_byte(in_data_byte, in_end_of_string);
      end
    end
    units_pending = units_due.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the transcoder testbench: clock, reset, byte stimulus, receiver stalls and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import u8u16_pkg::*;

  localparam int DirectedCount = 24;
  localparam int RandomBytes   = 500;
  localparam int CalmTail      = 100;
  localparam int LongHold      = 48;
  localparam int QuietLimit    = 2000;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   units_pending;
  int   bytes_sent;
  int   quiet_cycles = 0;
  bit   idle_on;
  bit   hold_req;

  u8u16_in_if  in_chan ();
  u8u16_out_if out_chan ();

  // Directed bytes, end_of_string in bit 8.
  logic [8:0] directed_beats [DirectedCount] = '{
    9'h000, 9'h07F,                          // ASCII extremes
    9'h0DF, 9'h0BF,                          // largest two-byte value
    9'h0C0, 9'h080,                          // overlong form passes unchecked
    9'h0EF, 9'h0BF, 9'h0BF,                  // 0xFFFF
    9'h0F0, 9'h09F, 9'h098, 9'h080,          // supplementary, surrogate pair
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,          // largest four-byte value
    9'h080, 9'h0FF,                          // stray bytes
    9'h0E2, 9'h041,                          // broken sequence restarts as ASCII
    9'h0E2, 9'h182,                          // truncated at end of string
    9'h141                                   // complete unit at end of string
  };

  always #4 clk = ~clk;

  utf8_to_utf16_transcoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  u8u16_stream_check unit_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_chan.valid),
    .in_ready         (in_chan.ready),
    .in_data_byte     (in_chan.data_byte),
    .in_end_of_string (in_chan.end_of_string),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_code_unit    (out_chan.code_unit),
    .out_last_of_run  (out_chan.last_of_run),
    .out_string_end   (out_chan.string_end),
    .fail_count       (fail_count),
    .units_pending    (units_pending)
  );

  // Offer one byte beat, with an occasional idle burst first, and wait until
  // it is taken. Entered and left just after a falling edge.
  task automatic send_beat(input byte_t b, input logic eos);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.data_byte     <= b;
    in_chan.end_of_string <= eos;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Well-formed character of the given byte length with random payload bits.
  task automatic send_char(input int len, input bit eos_last);
    byte_t lead;
    int    k;
    case (len)
      1:       lead = {1'b0, 7'($urandom)};
      2:       lead = {3'b110, 5'($urandom)};
      3:       lead = {4'b1110, 4'($urandom)};
      default: lead = {5'b11110, 3'($urandom)};
    endcase
    send_beat(lead, eos_last && len == 1);
    for (k = 1; k < len; k++) begin
      send_beat({2'b10, 6'($urandom)}, eos_last && k == len - 1);
    end
  endtask

  // Multi-byte sequence cut short, either by the end of the string or by a new lead.
  task automatic send_cut(input bit at_end);
    int len;
    int conts;
    int k;
    len   = $urandom_range(2, 4);
    conts = $urandom_range(0, len - 2);
    send_beat(byte_t'(8'hFF << (8 - len)) | byte_t'($urandom & (8'h7F >> len)),
              at_end && conts == 0);
    for (k = 0; k < conts; k++) begin
      send_beat({2'b10, 6'($urandom)}, at_end && k == conts - 1);
    end
    if (!at_end) begin
      send_char($urandom_range(1, 4), 1'b0);
    end
  endtask

  // Stimulus: reset, directed bytes, then mostly well-formed random text.
  initial begin
    int k;
    int pick;
    in_chan.valid         = 1'b0;
    in_chan.data_byte     = '0;
    in_chan.end_of_string = 1'b0;
    rst_n                 = 1'b0;
    idle_on               = 1'b1;
    hold_req              = 1'b0;
    bytes_sent            = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DirectedCount; k++) begin
      send_beat(directed_beats[k][7:0], directed_beats[k][8]);
    end

    // The receiver holds off for a while as the random part begins.
    hold_req = 1'b1;
    while (bytes_sent < DirectedCount + RandomBytes) begin
      if (bytes_sent > DirectedCount + RandomBytes - CalmTail) begin
        idle_on = 1'b0;
      end
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        send_char($urandom_range(1, 4), $urandom_range(0, 9) == 0);
      end else if (pick < 17) begin
        send_beat(byte_t'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        send_cut(pick == 19);
      end
    end
    in_chan.valid <= 1'b0;

    // Drain, then give the block time to show any extra unit.
    while (units_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_count == 0 && units_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: ready with random stall bursts, and one long hold-off on request.
  initial begin
    bit held;
    held           = 1'b0;
    out_chan.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
src/u8u16_pkg.sv
src/u8u16_ifs.sv
src/utf8_to_utf16_transcoder_top.sv
tb/sv/u8u16_stream_check.sv
tb/sv/tb_top.sv
